// ===== rtl/sst_pkg.sv =====
// shared constants, codes and control types for the small set table
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

   localparam int CAPACITY = 16;
   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;
   localparam int COUNT_W  = 5;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SCAN_W   = IDX_W + 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CNT_X_W  = CNT_W + COUNT_W;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } sst_state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } sst_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } sst_sts_type;

endpackage
`default_nettype wire

// ===== rtl/sst_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module sst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/sst_ctrl.sv =====
// sequencer: accept, scan the entries, then commit and hand off the result
`timescale 1ns / 1ps
`default_nettype none
module sst_ctrl import sst_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire sst_sts_type sts,
   output sst_cmd_type      cmd
);

   sst_state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // wait until the result register can take the new beat
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/sst_dpath.sv =====
// datapath: entry store, valid marks, scan compare, count and result register
`timescale 1ns / 1ps
`default_nettype none
module sst_dpath import sst_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sst_cmd_type               cmd,
   output sst_sts_type                    sts,
   input  wire logic [OP_W-1:0]           req_op,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_success,
   output logic                           rsp_full_reject,
   output logic [COUNT_W-1:0]             rsp_count,
   output logic                           rsp_is_empty
);

   logic [OP_W-1:0]    op_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               success_ff, full_ff, empty_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [VALUE_W-1:0] rd_data;
   logic               scan_end;
   logic               add_ok, add_full, rem_ok, qry_ok;
   logic [CNT_X_W-1:0] held_x;

   sst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && add_ok),
      .wr_addr (free_idx_ff),
      .wr_data (value_ff),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign scan_end = (scan_ff == SCAN_W'(CAPACITY));

   // scan: one entry read per cycle, compared in the cycle after its read
   always_comb begin
      scan_in     = scan_ff;
      chk_vld_in  = 1'b0;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (cmd.start) begin
         scan_in = '0;
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else begin
         if (cmd.scan && !scan_end) begin
            scan_in    = scan_ff + SCAN_W'(1);
            chk_vld_in = 1'b1;
         end
         if (chk_vld_ff) begin
            if (valid_ff[chk_idx_ff] && (rd_data == value_ff) && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
            end
            // lowest free slot wins
            if (!valid_ff[chk_idx_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = chk_idx_ff;
            end
         end
      end
   end

   assign add_ok   = (op_ff == OP_ADD) && !hit_ff && free_ff;
   assign add_full = (op_ff == OP_ADD) && !hit_ff && !free_ff;
   assign rem_ok   = (op_ff == OP_REMOVE) && hit_ff;
   assign qry_ok   = (op_ff == OP_QUERY) && hit_ff;

   always_comb begin
      valid_in = valid_ff;
      held_in  = held_ff;
      if (cmd.commit) begin
         if (add_ok) begin
            valid_in[free_idx_ff] = 1'b1;
            held_in               = held_ff + CNT_W'(1);
         end else if (rem_ok) begin
            valid_in[hit_idx_ff] = 1'b0;
            held_in              = held_ff - CNT_W'(1);
         end
      end
   end

   assign held_x = CNT_X_W'(held_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         valid_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         chk_vld_ff   <= chk_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         valid_ff     <= valid_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= req_op;
         value_ff <= req_value;
      end
      chk_idx_ff  <= scan_ff[IDX_W-1:0];
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      if (cmd.commit) begin
         success_ff <= add_ok || rem_ok || qry_ok;
         full_ff    <= add_full;
         count_ff   <= held_x[COUNT_W-1:0];
         empty_ff   <= (held_in == '0);
      end
   end

   assign sts = '{scan_done: scan_end, out_free: (!rsp_valid_ff || rsp_ready)};

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = success_ff;
   assign rsp_full_reject = full_ff;
   assign rsp_count       = count_ff;
   assign rsp_is_empty    = empty_ff;

endmodule
`default_nettype wire

// ===== rtl/small_set_table.sv =====
// top level of the small set table: bounded set with add, remove and query
//
//   channel | ports                                   | direction
//   req     | req_valid req_ready req_op req_value    | in
//   rsp     | rsp_valid rsp_ready rsp_success         | out
//           | rsp_full_reject rsp_count rsp_is_empty  |
//
// each item is accepted, then the scan walks the entry ram one address a cycle,
// then the item is committed; a new item is taken only after that commit
// reset clears the valid marks and the count at once; no clearing pass
// the commit waits while an earlier result beat is still not taken
`timescale 1ns / 1ps
`default_nettype none
module small_set_table import sst_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [OP_W-1:0]           req_op,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_success,
   output logic                           rsp_full_reject,
   output logic [COUNT_W-1:0]             rsp_count,
   output logic                           rsp_is_empty
);

   sst_cmd_type cmd;
   sst_sts_type sts;

   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sst_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_op),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_success     (rsp_success),
      .rsp_full_reject (rsp_full_reject),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty)
   );

`ifndef NO_ASSERTIONS
   a_full_not_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_reject |-> !rsp_success && !rsp_is_empty)
      else $error("full reject beat reports success or empty set");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new beat taken while the previous one is still scanning");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("result beat raised without a commit");
`endif

endmodule
`default_nettype wire
